// File: design/integer_field_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer field formatter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define IFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/iff_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Types, constants and character helpers shared by the formatter modules.
// ----------------------------------------------------------------------------
package iff_pkg;

  // Field width saturates at this many characters.
  localparam int WIDTH_LIMIT = 64;

  // Digit buffer: octal needs the most digits of a 64-bit pattern.
  localparam int DIG_COUNT = 22;
  localparam int DIG_IDX_W = $clog2(DIG_COUNT);

  // Decimal conversion: BCD digits and value bits shifted per cycle.
  localparam int BCD_DIGITS   = 20;
  localparam int BCD_BITS     = 4 * BCD_DIGITS;
  localparam int BITS_PER_CYC = 4;
  localparam int CONV_CYCLES  = 64 / BITS_PER_CYC;
  localparam int CONV_CNT_W   = $clog2(CONV_CYCLES);

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Base selection codes.
  localparam logic [1:0] OP_DEC  = 2'd0;
  localparam logic [1:0] OP_OCT  = 2'd1;
  localparam logic [1:0] OP_HEXL = 2'd2;
  localparam logic [1:0] OP_HEXU = 2'd3;

  // ASCII characters used by the formatter.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  // Sign that precedes the digits.
  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_MINUS = 2'd1,
    SIGN_PLUS  = 2'd2,
    SIGN_SPACE = 2'd3
  } sign_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  opcode;
    logic [6:0]  width;
    sign_t       sign;
    logic        left;
    logic        zpad;
    logic        center;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ASCII character of one digit value.
  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else if (upper) begin
      c = CH_UPPER + {4'b0, d} - 8'd10;
    end else begin
      c = CH_LOWER + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

  // ASCII character of a sign code.
  function automatic logic [7:0] sign_char(sign_t s);
    logic [7:0] c;
    case (s)
      SIGN_MINUS: c = CH_MINUS;
      SIGN_PLUS:  c = CH_PLUS;
      default:    c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

// File: design/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats a 64-bit value as a padded ASCII field in decimal, octal or hex,
// one character word per cycle while a field streams and out_stall is low, with the final word marked.
// ----------------------------------------------------------------------------
// After input acceptance a decimal job runs the BCD conversion loop (4 bits per
// cycle) before the field is sized and streamed; octal/hex jobs skip the loop.
// One word per cycle while a field streams and out_stall is low; a queued item
// is popped only once the last word of the previous field has been loaded.
// A two-entry job queue lets the front accept items while the back is busy.
// Reset (synchronous, rst high) empties the queue and clears the output valid.
module integer_field_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  input  logic [1:0]  opcode,
  input  logic [6:0]  field_width,
  input  logic        left_align,
  input  logic        zero_pad,
  input  logic        show_plus,
  input  logic        space_sign,
  input  logic        center_align,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_char
);

  iff_pkg::q_stat_t q_stat;
  iff_pkg::job_t    push_job;
  iff_pkg::job_t    pop_job;
  logic             push;
  logic             pop;

  // Front end: classify and enqueue.
  iff_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .opcode       (opcode),
    .field_width  (field_width),
    .left_align   (left_align),
    .zero_pad     (zero_pad),
    .show_plus    (show_plus),
    .space_sign   (space_sign),
    .center_align (center_align),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  // Job queue between the two halves.
  iff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // Back end: convert and stream characters.
  iff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

// File: design/iff_front.sv
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts input words, resolves sign and magnitude, saturates the width and
// pushes a classified job into the queue.
// ----------------------------------------------------------------------------
module iff_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          value,
  input  logic [1:0]           opcode,
  input  logic [6:0]           field_width,
  input  logic                 left_align,
  input  logic                 zero_pad,
  input  logic                 show_plus,
  input  logic                 space_sign,
  input  logic                 center_align,
  input  iff_pkg::q_stat_t     q_stat,
  output logic                 push,
  output iff_pkg::job_t        push_job
);

  // A word is taken whenever the queue has room.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the word: only decimal carries a sign.
  always_comb begin
    push_job.mag    = value;
    push_job.opcode = opcode;
    push_job.sign   = iff_pkg::SIGN_NONE;
    if (opcode == iff_pkg::OP_DEC) begin
      if (value[63]) begin
        push_job.sign = iff_pkg::SIGN_MINUS;
        push_job.mag  = (~value) + 64'd1;
      end else if (show_plus) begin
        push_job.sign = iff_pkg::SIGN_PLUS;
      end else if (space_sign) begin
        push_job.sign = iff_pkg::SIGN_SPACE;
      end
    end
    if (field_width > 7'(iff_pkg::WIDTH_LIMIT)) begin
      push_job.width = 7'(iff_pkg::WIDTH_LIMIT);
    end else begin
      push_job.width = field_width;
    end
    push_job.left   = left_align;
    push_job.zpad   = zero_pad;
    push_job.center = center_align;
  end

endmodule

// File: design/iff_queue.sv
// ----------------------------------------------------------------------------
// Formatter job queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module iff_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  iff_pkg::job_t     push_job,
  input  logic              pop,
  output iff_pkg::job_t     pop_job,
  output iff_pkg::q_stat_t  q_stat
);

  iff_pkg::job_t                 slots [iff_pkg::QUEUE_DEPTH];
  logic [iff_pkg::QPTR_W-1:0]    wptr;
  logic [iff_pkg::QPTR_W-1:0]    rptr;
  logic [iff_pkg::QPTR_W:0]      count;

  assign q_stat.full  = (count == (iff_pkg::QPTR_W + 1)'(iff_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_job      = slots[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == iff_pkg::QPTR_W'(iff_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == iff_pkg::QPTR_W'(iff_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

// File: design/iff_back.sv
// ----------------------------------------------------------------------------
// Formatter back end
// Converts a job into digits, lays out the padded field and streams its
// characters through an output register, one word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "integer_field_formatter_assert.svh"

module iff_back (
  input  logic              clk,
  input  logic              rst,
  input  iff_pkg::q_stat_t  q_stat,
  input  iff_pkg::job_t     pop_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              last_char
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                             state;
  iff_pkg::job_t                      job;
  logic [63:0]                        mag;
  logic [iff_pkg::BCD_BITS-1:0]       bcd;
  logic [iff_pkg::CONV_CNT_W-1:0]     cnt;
  logic [3:0]                         dig [iff_pkg::DIG_COUNT];
  logic [6:0]                         b0, b1, b2, b3, total;
  logic [7:0]                         lch;
  logic [6:0]                         pos;

  logic [63:0]                        mag_next;
  logic [iff_pkg::BCD_BITS-1:0]       bcd_next;
  logic [3:0]                         raw_dig [iff_pkg::DIG_COUNT];
  logic [4:0]                         ndig;
  logic                               has_sign;
  logic                               sign_pre;
  logic [6:0]                         len, pad, lpad, rpad;
  logic [7:0]                         lch_next;
  logic [6:0]                         didx_full;
  logic [7:0]                         ch;
  logic                               load;
  logic                               is_last;

  // A new job is taken only once the previous field has been issued.
  assign pop = (state == S_IDLE) && !q_stat.empty;

  // Double dabble, several value bits per cycle, most significant first.
  always_comb begin
    bcd_next = bcd;
    mag_next = mag;
    for (int s = 0; s < iff_pkg::BITS_PER_CYC; s++) begin
      for (int d = 0; d < iff_pkg::BCD_DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[iff_pkg::BCD_BITS-2:0], mag_next[63]};
      mag_next = {mag_next[62:0], 1'b0};
    end
  end

  // Octal and hex digits come straight from the bit pattern.
  always_comb begin
    logic [65:0] ext;
    ext = {2'b00, pop_job.mag};
    for (int i = 0; i < iff_pkg::DIG_COUNT; i++) begin
      if (pop_job.opcode == iff_pkg::OP_OCT) begin
        raw_dig[i] = {1'b0, ext[3*i +: 3]};
      end else if (i < 16) begin
        raw_dig[i] = ext[4*i +: 4];
      end else begin
        raw_dig[i] = 4'd0;
      end
    end
  end

  // Digit count: highest nonzero digit, at least one.
  always_comb begin
    logic [4:0] hi;
    hi = 5'd0;
    for (int i = 0; i < iff_pkg::DIG_COUNT; i++) begin
      if (dig[i] != 4'd0) begin
        hi = 5'(i + 1);
      end
    end
    ndig = (hi == 5'd0) ? 5'd1 : hi;
  end

  // Field layout: optional leading sign, left pad, sign, digits, right pad.
  always_comb begin
    has_sign = (job.sign != iff_pkg::SIGN_NONE);
    sign_pre = has_sign && job.zpad && !job.left;
    len      = {2'b00, ndig} + {6'b0, has_sign};
    pad      = (job.width > len) ? job.width - len : 7'd0;
    lpad     = 7'd0;
    rpad     = 7'd0;
    lch_next = iff_pkg::CH_SPACE;
    if (sign_pre) begin
      lpad     = pad;
      lch_next = iff_pkg::CH_ZERO;
    end else if (job.center && pad != 7'd0) begin
      lpad = {1'b0, pad[6:1]};
      rpad = pad - {1'b0, pad[6:1]};
    end else if (job.left) begin
      rpad = pad;
    end else begin
      lpad     = pad;
      lch_next = job.zpad ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
    end
  end

  // Character at the current position of the field.
  always_comb begin
    didx_full = b3 - 7'd1 - pos;
    if (pos < b0) begin
      ch = iff_pkg::sign_char(job.sign);
    end else if (pos < b1) begin
      ch = lch;
    end else if (pos < b2) begin
      ch = iff_pkg::sign_char(job.sign);
    end else if (pos < b3) begin
      ch = iff_pkg::digit_char(dig[didx_full[iff_pkg::DIG_IDX_W-1:0]],
                               job.opcode == iff_pkg::OP_HEXU);
    end else begin
      ch = iff_pkg::CH_SPACE;
    end
  end

  assign load    = (state == S_EMIT) && (!out_valid || !out_stall);
  assign is_last = (pos == total - 7'd1);

  // Sequencer: take a job, convert it (decimal only), size the field, stream it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= (pop_job.opcode == iff_pkg::OP_DEC) ? S_CONV : S_SIZE;
          end
        end
        S_CONV: begin
          if (cnt == iff_pkg::CONV_CNT_W'(iff_pkg::CONV_CYCLES - 1)) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load && is_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Job payload, conversion registers and layout boundaries.
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
      mag <= pop_job.mag;
      bcd <= '0;
      cnt <= '0;
      for (int i = 0; i < iff_pkg::DIG_COUNT; i++) begin
        dig[i] <= raw_dig[i];
      end
    end
    if (state == S_CONV) begin
      mag <= mag_next;
      bcd <= bcd_next;
      cnt <= cnt + 1'b1;
      if (cnt == iff_pkg::CONV_CNT_W'(iff_pkg::CONV_CYCLES - 1)) begin
        for (int i = 0; i < iff_pkg::DIG_COUNT; i++) begin
          if (i < iff_pkg::BCD_DIGITS) begin
            dig[i] <= bcd_next[4*i +: 4];
          end else begin
            dig[i] <= 4'd0;
          end
        end
      end
    end
    if (state == S_SIZE) begin
      b0    <= {6'b0, sign_pre};
      b1    <= {6'b0, sign_pre} + lpad;
      b2    <= {6'b0, sign_pre} + lpad + {6'b0, has_sign && !sign_pre};
      b3    <= {6'b0, has_sign} + lpad + {2'b00, ndig};
      total <= {6'b0, has_sign} + lpad + {2'b00, ndig} + rpad;
      lch   <= lch_next;
      pos   <= 7'd0;
    end
    if (load) begin
      pos <= pos + 7'd1;
    end
  end

  // Output register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= ch;
      last_char <= is_last;
    end
  end

  // The emit position stays inside the field and the field inside the limit.
  `IFF_ASSERT_NOW(a_pos_in_field, state == S_EMIT, pos < total, "emit position past field end")
  `IFF_ASSERT_NOW(a_field_limit, state == S_EMIT, total <= 7'(iff_pkg::WIDTH_LIMIT), "field too long")
  // Only decimal jobs run the conversion loop.
  `IFF_ASSERT_NOW(a_conv_decimal, state == S_CONV, job.opcode == iff_pkg::OP_DEC, "non-decimal in conversion")
  // No job is popped while a field is in progress.
  `IFF_ASSERT_NOW(a_pop_idle, pop, state == S_IDLE, "pop outside idle")
  // Finishing a field returns the sequencer to idle.
  `IFF_ASSERT_NEXT(a_last_idle, load && is_last, state == S_IDLE, "no return to idle after last word")

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// A queue of format requests feeds a clocked driver. Every accepted word is
// run through a predictor in the bench, which appends the expected field
// characters to a queue. A clocked monitor compares each output word with the
// oldest expected character, checking both the character and its last mark.
// Both sides idle and stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module testbench;

  // One format request as it waits to be driven.
  typedef struct {
    logic [63:0] value;
    logic [1:0]  opcode;
    logic [6:0]  fwidth;
    logic        left;
    logic        zpad;
    logic        plus;
    logic        space;
    logic        center;
    bit          wait_drain;
  } fmt_req_t;

  // One expected output character.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] value = '0;
  logic [1:0]  opcode = iff_pkg::OP_DEC;
  logic [6:0]  field_width = '0;
  logic        left_align = 1'b0;
  logic        zero_pad = 1'b0;
  logic        show_plus = 1'b0;
  logic        space_sign = 1'b0;
  logic        center_align = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last_char;

  fmt_req_t  field_requests[$];
  char_rec_t pending_chars[$];
  fmt_req_t  cur_request;
  char_rec_t oldest_char;

  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int fields_sent = 0;
  int fields_done = 0;
  int chars_checked = 0;

  integer_field_formatter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .opcode       (opcode),
    .field_width  (field_width),
    .left_align   (left_align),
    .zero_pad     (zero_pad),
    .show_plus    (show_plus),
    .space_sign   (space_sign),
    .center_align (center_align),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .last_char    (last_char)
  );

  always #2 clk = ~clk;

  // Works out the characters of one formatted field and queues them.
  function automatic void format_field(input fmt_req_t r);
    logic [7:0]  digs[$];
    logic [7:0]  txt[$];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    logic [7:0]  sign_ch;
    logic [7:0]  lch;
    bit          has_sign;
    bit          upper;
    int          fw, len, pad, lpad, rpad;
    char_rec_t   rec;
    mag = r.value;
    has_sign = 1'b0;
    sign_ch = iff_pkg::CH_SPACE;
    upper = (r.opcode == iff_pkg::OP_HEXU);
    fw = (r.fwidth > iff_pkg::WIDTH_LIMIT) ? iff_pkg::WIDTH_LIMIT : int'(r.fwidth);
    case (r.opcode)
      iff_pkg::OP_DEC: radix = 64'd10;
      iff_pkg::OP_OCT: radix = 64'd8;
      default:         radix = 64'd16;
    endcase

    // Only decimal carries a sign; other bases print the raw pattern.
    if (r.opcode == iff_pkg::OP_DEC) begin
      if (r.value[63]) begin
        has_sign = 1'b1;
        sign_ch = iff_pkg::CH_MINUS;
        mag = ~r.value + 64'd1;
      end else if (r.plus) begin
        has_sign = 1'b1;
        sign_ch = iff_pkg::CH_PLUS;
      end else if (r.space) begin
        has_sign = 1'b1;
        sign_ch = iff_pkg::CH_SPACE;
      end
    end

    // Digits, most significant first.
    do begin
      d = mag % radix;
      if (d < 64'd10) begin
        digs.push_front(iff_pkg::CH_ZERO + d[7:0]);
      end else begin
        digs.push_front((upper ? iff_pkg::CH_UPPER : iff_pkg::CH_LOWER) + d[7:0] - 8'd10);
      end
      mag = mag / radix;
    end while (mag != 64'd0);

    if (has_sign && r.zpad && !r.left) begin
      // Sign first, then zeros up to the width, then the digits.
      txt.push_back(sign_ch);
      for (int i = digs.size() + 1; i < fw; i++) txt.push_back(iff_pkg::CH_ZERO);
      foreach (digs[i]) txt.push_back(digs[i]);
    end else begin
      len = digs.size() + (has_sign ? 1 : 0);
      pad = (fw > len) ? fw - len : 0;
      lpad = 0;
      rpad = 0;
      lch = iff_pkg::CH_SPACE;
      if (r.center && pad > 0) begin
        lpad = pad / 2;
        rpad = pad - lpad;
      end else if (r.left) begin
        rpad = pad;
      end else begin
        lpad = pad;
        lch = r.zpad ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
      end
      repeat (lpad) txt.push_back(lch);
      if (has_sign) txt.push_back(sign_ch);
      foreach (digs[i]) txt.push_back(digs[i]);
      repeat (rpad) txt.push_back(iff_pkg::CH_SPACE);
    end

    foreach (txt[i]) begin
      rec.ch = txt[i];
      rec.last = (i == txt.size() - 1);
      pending_chars.push_back(rec);
    end
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic add_request(input logic [63:0] v, input logic [1:0] op, input int w,
                             input bit l, input bit z, input bit p, input bit s,
                             input bit c, input bit drain);
    fmt_req_t r;
    r.value = v;
    r.opcode = op;
    r.fwidth = w[6:0];
    r.left = l;
    r.zpad = z;
    r.plus = p;
    r.space = s;
    r.center = c;
    r.wait_drain = drain;
    field_requests.push_back(r);
  endtask

  // Random value drawn from several classes, boundaries among them.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int cls;
    cls = $urandom_range(0, 9);
    case (cls)
      0, 1, 2: v = {$urandom, $urandom};
      3, 4:    v = 64'($urandom_range(0, 2000));
      5: begin
        case ($urandom_range(0, 4))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = 64'd0;
          3: v = '1;
          default: v = 64'd1;
        endcase
      end
      6: begin
        v = 64'd1;
        repeat ($urandom_range(0, 18)) v = v * 64'd10;
        if ($urandom_range(0, 1)) v = v - 64'd1;
      end
      7: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {{32{1'b0}}, $urandom};
    endcase
    if (cls != 5 && $urandom_range(0, 2) == 0) v = ~v + 64'd1;
    return v;
  endfunction

  function automatic int rand_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 8);
    if (r < 55) return $urandom_range(0, 24);
    if (r < 85) return $urandom_range(0, 64);
    return $urandom_range(65, 127);
  endfunction

  task automatic add_random(input int count);
    repeat (count) begin
      add_request(rand_value(), 2'($urandom_range(0, 3)), rand_width(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)),
                  $urandom_range(0, 39) == 0);
    end
  endtask

  task automatic wait_sent();
    while (field_requests.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Driver: presents the next request once the bus is free.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        format_field(cur_request);
        fields_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (field_requests.size() != 0 &&
                     !(field_requests[0].wait_drain && pending_chars.size() != 0)) begin
          cur_request = field_requests.pop_front();
          value <= cur_request.value;
          opcode <= cur_request.opcode;
          field_width <= cur_request.fwidth;
          left_align <= cur_request.left;
          zero_pad <= cur_request.zpad;
          show_plus <= cur_request.plus;
          space_sign <= cur_request.space;
          center_align <= cur_request.center;
          in_valid <= 1'b1;
          gap_left <= sender_gaps ? pick_idle() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted word and sets the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%h last=%b", out_char, last_char));
        end else begin
          oldest_char = pending_chars.pop_front();
          chars_checked++;
          if (out_char !== oldest_char.ch)
            report_mismatch($sformatf("char got %h want %h", out_char, oldest_char.ch));
          if (last_char !== oldest_char.last)
            report_mismatch($sformatf("last got %b want %b (char %h)", last_char,
                                      oldest_char.last, oldest_char.ch));
          if (oldest_char.last) fields_done++;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
        stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(7, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed fields: extremes, every base and each padding rule.
    add_request(64'd0, iff_pkg::OP_DEC, 0, 0, 0, 0, 0, 0, 0);
    add_request(64'h8000_0000_0000_0000, iff_pkg::OP_DEC, 0, 0, 0, 0, 0, 0, 0);
    add_request(64'h7FFF_FFFF_FFFF_FFFF, iff_pkg::OP_DEC, 0, 0, 0, 0, 0, 0, 0);
    add_request('1, iff_pkg::OP_OCT, 0, 0, 0, 1, 1, 0, 0);
    add_request('1, iff_pkg::OP_HEXL, 0, 0, 0, 0, 0, 0, 0);
    add_request('1, iff_pkg::OP_HEXU, 0, 0, 0, 0, 0, 0, 0);
    add_request(64'hFEDC_BA98_7654_3210, iff_pkg::OP_HEXL, 20, 0, 1, 0, 0, 0, 0);
    add_request(64'hFEDC_BA98_7654_3210, iff_pkg::OP_HEXU, 20, 1, 1, 0, 0, 0, 0);
    add_request(64'd42, iff_pkg::OP_DEC, 8, 0, 1, 1, 0, 0, 1);
    add_request(-64'sd42, iff_pkg::OP_DEC, 8, 0, 1, 0, 0, 1, 0);
    add_request(64'd42, iff_pkg::OP_DEC, 6, 1, 1, 0, 1, 0, 0);
    add_request(64'd7, iff_pkg::OP_DEC, 10, 0, 0, 0, 0, 1, 0);
    add_request(64'd123, iff_pkg::OP_DEC, 3, 1, 1, 0, 0, 1, 0);
    add_request(64'd5, iff_pkg::OP_OCT, 6, 0, 1, 1, 1, 0, 0);
    add_request(64'd1, iff_pkg::OP_DEC, 127, 0, 0, 0, 0, 0, 0);
    add_request(64'hABC, iff_pkg::OP_HEXL, 64, 1, 0, 0, 0, 0, 0);
    add_request(64'd99, iff_pkg::OP_DEC, 65, 0, 1, 0, 0, 0, 0);
    add_request(64'd12345678, iff_pkg::OP_DEC, 3, 0, 0, 1, 0, 0, 0);
    add_request(64'd9, iff_pkg::OP_DEC, 4, 0, 0, 1, 1, 0, 0);
    add_request(64'd5, iff_pkg::OP_DEC, 0, 0, 0, 0, 1, 0, 0);
    add_request(64'd42, iff_pkg::OP_DEC, 6, 0, 1, 0, 0, 0, 0);
    add_request(-64'sd5, iff_pkg::OP_DEC, 7, 0, 0, 0, 0, 1, 0);
    add_request(64'h8000_0000_0000_0000, iff_pkg::OP_DEC, 64, 0, 1, 1, 0, 0, 0);
    add_request(64'h8000_0000_0000_0000, iff_pkg::OP_OCT, 30, 0, 0, 0, 0, 1, 1);
    wait_sent();

    // Random fields under changing idle patterns.
    add_random(160);
    wait_sent();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    add_random(90);
    wait_sent();
    sender_gaps = 1'b1;
    add_random(80);
    wait_sent();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b1;
    add_random(90);
    wait_sent();

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d fields, checked %0d characters over all bases and padding modes.",
             fields_sent, chars_checked);
    $display("Completed %0d fields, %0d mismatches.", fields_done, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Timeout with %0d characters outstanding.", pending_chars.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
